/* hw/rtl/hdp_pkg.sv */
// ----------------------------------------------------------------------------
// hdp_pkg
// Shared types and constants of the heading to differential PWM block.
// ----------------------------------------------------------------------------
package hdp_pkg;

  // queue between the classifier and the speed pipeline
  localparam int unsigned QUEUE_DEPTH = 4;

  // field widths
  localparam int unsigned BEARING_W = 12;
  localparam int unsigned BASE_W    = 8;
  localparam int unsigned DIFF_W    = 13;
  localparam int unsigned ABSDIFF_W = 11;
  localparam int unsigned DEADBAND_W = 11;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD = 1'd1;

  // register reset values
  localparam int unsigned DEADBAND_RESET     = 100;
  localparam int unsigned TIMER_PERIOD_RESET = 999;

  // bearing geometry, tenths of a degree
  localparam int unsigned HALF_TURN    = 1800;
  localparam int unsigned FULL_TURN    = 3600;
  localparam int unsigned QUARTER_TURN = 900;

  localparam int unsigned SPEED_MAX = 100;

  // reciprocals: floor(x / n) == (x * RECIP) >> SHIFT over the ranges used
  localparam int unsigned RECIP_10        = 205;
  localparam int unsigned RECIP_10_SHIFT  = 11;
  localparam int unsigned RECIP_900       = 298262;
  localparam int unsigned RECIP_900_SHIFT = 28;
  localparam int unsigned RECIP_100       = 10737419;
  localparam int unsigned RECIP_100_SHIFT = 30;

  // classified request as it waits in the queue
  typedef struct packed {
    logic                 dead;
    logic                 right_inner;
    logic [ABSDIFF_W-1:0] abs_diff;
    logic [BASE_W-1:0]    base;
  } item_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

/* hw/rtl/heading_to_differential_pwm.sv */
// ----------------------------------------------------------------------------
// heading_to_differential_pwm
// Turns a bearing error and base speed into signed wheel powers and PWM
// compare values for a two-wheeled vehicle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request holds current bearing, target bearing, base speed.
//           taken at a clock edge where in_valid is high and in_stall is low.
//   out_* : one result per request, in request order, taken where out_valid
//           is high and out_stall is low.
//   cfg_* : cfg_we writes cfg_wdata to the register at cfg_index
//           (deadband, timer period); write only while no request is in flight.
//   Throughput is one request per cycle while out_stall stays low. An
//   accepted request passes one classify stage, one queue slot and five
//   stages of the speed pipeline (two multiply stages for the inner wheel,
//   one clamp stage, two for the compare values) before its result can be
//   taken.
//   Reset empties the queue and the pipeline and loads deadband 100 and
//   timer period 999; in_stall is low right after.
//   When the receiver stalls, the result holds, the pipeline and the queue
//   fill, and in_stall rises once the queue is full and the classify stage
//   is occupied.
// ----------------------------------------------------------------------------
module heading_to_differential_pwm #(
  parameter int unsigned QUEUE_DEPTH = hdp_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hdp_pkg::BEARING_W-1:0]       in_current_bearing,
  input  logic [hdp_pkg::BEARING_W-1:0]       in_target_bearing,
  input  logic [hdp_pkg::BASE_W-1:0]          in_base_speed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hdp_pkg::SPEED_W-1:0]  out_left_speed,
  output logic signed [hdp_pkg::SPEED_W-1:0]  out_right_speed,
  output logic [hdp_pkg::PERIOD_W-1:0]        out_left_compare,
  output logic [hdp_pkg::PERIOD_W-1:0]        out_right_compare,
  output logic                                out_in_deadband,
  input  logic                                cfg_we,
  input  logic [hdp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hdp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [hdp_pkg::DEADBAND_W-1:0] deadband_r;
  logic [hdp_pkg::PERIOD_W-1:0]   timer_period_r;

  hdp_pkg::q_stat_t q_stat;
  hdp_pkg::item_t   push_item;
  hdp_pkg::item_t   head_item;
  logic             push;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r     <= hdp_pkg::DEADBAND_W'(hdp_pkg::DEADBAND_RESET);
      timer_period_r <= hdp_pkg::PERIOD_W'(hdp_pkg::TIMER_PERIOD_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        hdp_pkg::CFG_DEADBAND: begin
          deadband_r <= cfg_wdata[hdp_pkg::DEADBAND_W-1:0];
        end
        hdp_pkg::CFG_TIMER_PERIOD: begin
          timer_period_r <= cfg_wdata[hdp_pkg::PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  hdp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_current_bearing (in_current_bearing),
    .in_target_bearing  (in_target_bearing),
    .in_base_speed      (in_base_speed),
    .deadband_i         (deadband_r),
    .q_stat_i           (q_stat),
    .push_o             (push),
    .push_item_o        (push_item)
  );

  hdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .stat_o      (q_stat)
  );

  hdp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat_i          (q_stat),
    .head_i            (head_item),
    .pop_o             (pop),
    .timer_period_i    (timer_period_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_speed    (out_left_speed),
    .out_right_speed   (out_right_speed),
    .out_left_compare  (out_left_compare),
    .out_right_compare (out_right_compare),
    .out_in_deadband   (out_in_deadband)
  );

endmodule

/* hw/rtl/hdp_front.sv */
// ----------------------------------------------------------------------------
// hdp_front
// Accepts requests, forms the wrapped heading error and classifies it.
// ----------------------------------------------------------------------------
module hdp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hdp_pkg::BEARING_W-1:0]       in_current_bearing,
  input  logic [hdp_pkg::BEARING_W-1:0]       in_target_bearing,
  input  logic [hdp_pkg::BASE_W-1:0]          in_base_speed,
  input  logic [hdp_pkg::DEADBAND_W-1:0]      deadband_i,
  input  hdp_pkg::q_stat_t                    q_stat_i,
  output logic                                push_o,
  output hdp_pkg::item_t                      push_item_o
);

  localparam logic signed [hdp_pkg::DIFF_W-1:0] HALF_S =
    hdp_pkg::DIFF_W'(hdp_pkg::HALF_TURN);
  localparam logic signed [hdp_pkg::DIFF_W-1:0] FULL_S =
    hdp_pkg::DIFF_W'(hdp_pkg::FULL_TURN);

  logic                                valid_r;
  logic signed [hdp_pkg::DIFF_W-1:0]   diff_r, diff_nxt;
  logic [hdp_pkg::BASE_W-1:0]          base_r;
  logic signed [hdp_pkg::DIFF_W-1:0]   diff_raw;
  logic signed [hdp_pkg::DIFF_W-1:0]   diff_abs;
  logic [hdp_pkg::ABSDIFF_W-1:0]       abs_diff;
  logic                                ready;

  assign ready    = !valid_r || !q_stat_i.full;
  assign in_stall = !ready;

  // one wrap toward the half turn
  always_comb begin
    diff_raw = $signed({1'b0, in_target_bearing}) - $signed({1'b0, in_current_bearing});
    if (diff_raw > HALF_S) begin
      diff_nxt = diff_raw - FULL_S;
    end else if (diff_raw < -HALF_S) begin
      diff_nxt = diff_raw + FULL_S;
    end else begin
      diff_nxt = diff_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= in_valid;
    end
    if (ready) begin
      diff_r <= diff_nxt;
      base_r <= in_base_speed;
    end
  end

  always_comb begin
    diff_abs = (diff_r < 0) ? -diff_r : diff_r;
    abs_diff = diff_abs[hdp_pkg::ABSDIFF_W-1:0];
  end

  assign push_o                  = valid_r && !q_stat_i.full;
  assign push_item_o.dead        = abs_diff < deadband_i;
  assign push_item_o.right_inner = diff_r > 0;
  assign push_item_o.abs_diff    = abs_diff;
  assign push_item_o.base        = base_r;

endmodule

/* hw/rtl/hdp_queue.sv */
// ----------------------------------------------------------------------------
// hdp_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module hdp_queue #(
  parameter int unsigned DEPTH = hdp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  hdp_pkg::item_t   push_item_i,
  input  logic             pop_i,
  output hdp_pkg::item_t   head_o,
  output hdp_pkg::q_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hdp_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

  assign head_o       = mem_r[rd_ptr_r];
  assign stat_o.full  = count_r == FULL_CNT;
  assign stat_o.valid = count_r != '0;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> count_r != FULL_CNT)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> count_r != '0)
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

/* hw/rtl/hdp_back.sv */
// ----------------------------------------------------------------------------
// hdp_back
// Speed and compare pipeline: inner wheel scaling, threshold, clamp, PWM.
// ----------------------------------------------------------------------------
module hdp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hdp_pkg::q_stat_t                  q_stat_i,
  input  hdp_pkg::item_t                    head_i,
  output logic                              pop_o,
  input  logic [hdp_pkg::PERIOD_W-1:0]      timer_period_i,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hdp_pkg::SPEED_W-1:0] out_left_speed,
  output logic signed [hdp_pkg::SPEED_W-1:0] out_right_speed,
  output logic [hdp_pkg::PERIOD_W-1:0]      out_left_compare,
  output logic [hdp_pkg::PERIOD_W-1:0]      out_right_compare,
  output logic                              out_in_deadband
);

  localparam int unsigned DMAG_W = 10;
  localparam int unsigned M1_W   = hdp_pkg::BASE_W + DMAG_W;
  localparam int unsigned R9_W   = 19;
  localparam int unsigned P2_W   = M1_W + R9_W;
  localparam int unsigned THR_W  = 5;
  localparam int unsigned MAG_W  = 7;
  localparam int unsigned LP_W   = hdp_pkg::PERIOD_W + MAG_W;
  localparam int unsigned R1_W   = 24;
  localparam int unsigned P5_W   = LP_W + R1_W;
  localparam int unsigned TP_W   = 16;

  localparam logic [hdp_pkg::ABSDIFF_W-1:0] QUARTER =
    hdp_pkg::ABSDIFF_W'(hdp_pkg::QUARTER_TURN);
  localparam logic [hdp_pkg::BASE_W-1:0] BASE_MAX = hdp_pkg::BASE_W'(hdp_pkg::SPEED_MAX);
  localparam logic [hdp_pkg::BASE_W-1:0] Q_MAX    = hdp_pkg::BASE_W'(hdp_pkg::SPEED_MAX);

  // stage ready chain, stage five is the output register
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1
  logic                      dead1_r, rin1_r, neg1_r;
  logic [M1_W-1:0]           m1_r, m1_nxt;
  logic [THR_W-1:0]          thr1_r, thr1_nxt;
  logic [MAG_W-1:0]          outer1_r, outer1_nxt;
  logic                      neg1_nxt;
  logic [DMAG_W-1:0]         dmag;
  logic [TP_W-1:0]           thr_prod;

  // stage 2
  logic                      dead2_r, rin2_r, neg2_r;
  logic [hdp_pkg::BASE_W-1:0] q2_r, q2_nxt;
  logic [THR_W-1:0]          thr2_r;
  logic [MAG_W-1:0]          outer2_r;
  logic [P2_W-1:0]           prod2;

  // stage 3
  logic                      dead3_r;
  logic [hdp_pkg::SPEED_W-1:0] lspd3_r, lspd3_nxt, rspd3_r, rspd3_nxt;
  logic [MAG_W-1:0]          lmag3_r, lmag3_nxt, rmag3_r, rmag3_nxt;
  logic [MAG_W-1:0]          imag;
  logic [hdp_pkg::SPEED_W-1:0] iext, ispd, ospd;

  // stage 4
  logic                      dead4_r;
  logic [hdp_pkg::SPEED_W-1:0] lspd4_r, rspd4_r;
  logic [LP_W-1:0]           lp4_r, lp4_nxt, rp4_r, rp4_nxt;

  // stage 5
  logic                      dead5_r;
  logic [hdp_pkg::SPEED_W-1:0] lspd5_r, rspd5_r;
  logic [hdp_pkg::PERIOD_W-1:0] lc5_r, lc5_nxt, rc5_r, rc5_nxt;
  logic [P5_W-1:0]           lprod5, rprod5;

  assign rdy5  = !v5_r || !out_stall;
  assign rdy4  = !v4_r || rdy5;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign pop_o = q_stat_i.valid && rdy1;

  // stage 1: base * |900 - |d||, base / 10, outer wheel clamp
  always_comb begin
    neg1_nxt = head_i.abs_diff > QUARTER;
    dmag = neg1_nxt ? DMAG_W'(head_i.abs_diff - QUARTER) : DMAG_W'(QUARTER - head_i.abs_diff);
    m1_nxt = {{DMAG_W{1'b0}}, head_i.base} * {{hdp_pkg::BASE_W{1'b0}}, dmag};
    thr_prod = {{(TP_W - hdp_pkg::BASE_W){1'b0}}, head_i.base} * TP_W'(hdp_pkg::RECIP_10);
    thr1_nxt = THR_W'(thr_prod >> hdp_pkg::RECIP_10_SHIFT);
    outer1_nxt = (head_i.base > BASE_MAX) ? MAG_W'(hdp_pkg::SPEED_MAX) : MAG_W'(head_i.base);
  end

  // stage 2: divide by 900 through the reciprocal
  always_comb begin
    prod2  = {{R9_W{1'b0}}, m1_r} * {{M1_W{1'b0}}, R9_W'(hdp_pkg::RECIP_900)};
    q2_nxt = hdp_pkg::BASE_W'(prod2 >> hdp_pkg::RECIP_900_SHIFT);
  end

  // stage 3: small-speed cut, clamp, wheel assignment
  always_comb begin
    if (q2_r < {{(hdp_pkg::BASE_W - THR_W){1'b0}}, thr2_r}) begin
      imag = '0;
    end else if (q2_r > Q_MAX) begin
      imag = MAG_W'(hdp_pkg::SPEED_MAX);
    end else begin
      imag = MAG_W'(q2_r);
    end
    iext = {1'b0, imag};
    ispd = neg2_r ? (~iext + 1'b1) : iext;
    ospd = {1'b0, outer2_r};
    if (dead2_r) begin
      lspd3_nxt = '0;
      rspd3_nxt = '0;
      lmag3_nxt = '0;
      rmag3_nxt = '0;
    end else if (rin2_r) begin
      lspd3_nxt = ospd;
      rspd3_nxt = ispd;
      lmag3_nxt = outer2_r;
      rmag3_nxt = imag;
    end else begin
      lspd3_nxt = ispd;
      rspd3_nxt = ospd;
      lmag3_nxt = imag;
      rmag3_nxt = outer2_r;
    end
  end

  // stage 4: period * |speed|
  always_comb begin
    lp4_nxt = {{MAG_W{1'b0}}, timer_period_i} * {{hdp_pkg::PERIOD_W{1'b0}}, lmag3_r};
    rp4_nxt = {{MAG_W{1'b0}}, timer_period_i} * {{hdp_pkg::PERIOD_W{1'b0}}, rmag3_r};
  end

  // stage 5: divide by 100 through the reciprocal
  always_comb begin
    lprod5  = {{R1_W{1'b0}}, lp4_r} * {{LP_W{1'b0}}, R1_W'(hdp_pkg::RECIP_100)};
    rprod5  = {{R1_W{1'b0}}, rp4_r} * {{LP_W{1'b0}}, R1_W'(hdp_pkg::RECIP_100)};
    lc5_nxt = hdp_pkg::PERIOD_W'(lprod5 >> hdp_pkg::RECIP_100_SHIFT);
    rc5_nxt = hdp_pkg::PERIOD_W'(rprod5 >> hdp_pkg::RECIP_100_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= q_stat_i.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
    if (rdy1) begin
      dead1_r  <= head_i.dead;
      rin1_r   <= head_i.right_inner;
      neg1_r   <= neg1_nxt;
      m1_r     <= m1_nxt;
      thr1_r   <= thr1_nxt;
      outer1_r <= outer1_nxt;
    end
    if (rdy2) begin
      dead2_r  <= dead1_r;
      rin2_r   <= rin1_r;
      neg2_r   <= neg1_r;
      q2_r     <= q2_nxt;
      thr2_r   <= thr1_r;
      outer2_r <= outer1_r;
    end
    if (rdy3) begin
      dead3_r <= dead2_r;
      lspd3_r <= lspd3_nxt;
      rspd3_r <= rspd3_nxt;
      lmag3_r <= lmag3_nxt;
      rmag3_r <= rmag3_nxt;
    end
    if (rdy4) begin
      dead4_r <= dead3_r;
      lspd4_r <= lspd3_r;
      rspd4_r <= rspd3_r;
      lp4_r   <= lp4_nxt;
      rp4_r   <= rp4_nxt;
    end
    if (rdy5) begin
      dead5_r <= dead4_r;
      lspd5_r <= lspd4_r;
      rspd5_r <= rspd4_r;
      lc5_r   <= lc5_nxt;
      rc5_r   <= rc5_nxt;
    end
  end

  assign out_valid         = v5_r;
  assign out_left_speed    = lspd5_r;
  assign out_right_speed   = rspd5_r;
  assign out_left_compare  = lc5_r;
  assign out_right_compare = rc5_r;
  assign out_in_deadband   = dead5_r;

  a_dead_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && dead3_r) |-> (lmag3_r == '0 && rmag3_r == '0))
    else $error("deadband request left a motor running");

  a_dead_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && dead5_r) |-> (lc5_r == '0 && rc5_r == '0))
    else $error("deadband request gave a nonzero compare");

endmodule
